// File: hw/rtl/pwm_tone_sequencer_unit_defines.svh
// Assertion macros shared by the tone sequencer RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef PWM_TONE_SEQUENCER_UNIT_DEFINES_SVH
`define PWM_TONE_SEQUENCER_UNIT_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define PTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pts: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define PTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pts: next-cycle check failed");

// condition must never hold
`define PTS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pts: forbidden condition seen");

`endif

// File: hw/rtl/pts_pkg.sv
// Shared types and constants of the tone sequencer.
// No dependencies; imported by every module of the block.
package pts_pkg;

    localparam int HZ_W     = 16;
    localparam int MS_W     = 16;
    localparam int PERIOD_W = 30;
    localparam int HIGH_W   = 29;
    localparam int QCNT_W   = 5;
    localparam int DIV_BITS = 30;
    localparam int BIT_W    = $clog2(DIV_BITS);

    // one second in nanoseconds, the fixed dividend of the period divider
    localparam logic [DIV_BITS-1:0] NS_PER_SEC = 30'd1000000000;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_BEEP = 2'd1,
        CMD_SET  = 2'd2
    } t_command;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic div_start;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

// File: hw/rtl/pts_ctrl.sv
// Sequencing controller of the tone sequencer: handshakes and step order.
// Depends on pts_pkg and the assertion macro header.
`include "pwm_tone_sequencer_unit_defines.svh"

module pts_ctrl
    import pts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_HOLD
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   load_ok;

    // command decode
    always_comb begin
        load_ok         = !r_out_valid || i_out_ready;
        o_cmd.exec      = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_start = (r_state == S_START);
        o_cmd.out_load  = (((r_state == S_DIV) && i_status.div_done) ||
                           (r_state == S_HOLD)) && load_ok;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_status.div_done) begin
                        r_state <= load_ok ? S_IDLE : S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `PTS_ASSERT_NEXT(a_start_follows_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_START)
    `PTS_ASSERT_IMPL(a_done_only_in_div, i_clk, i_rst_n, i_status.div_done, r_state == S_DIV)
    `PTS_ASSERT_IMPL(a_hold_has_pending, i_clk, i_rst_n, r_state == S_HOLD, r_out_valid)

endmodule

// File: hw/rtl/pts_div.sv
// Restoring bit-serial divider: one second in ns over the tone frequency.
// Depends on pts_pkg; one quotient bit per cycle.
module pts_div
    import pts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [HZ_W-1:0]     i_divisor,
    output logic [DIV_BITS-1:0] o_quotient,
    output logic                o_done
);

    logic                r_busy;
    logic                r_done;
    logic [BIT_W-1:0]    r_bit;
    logic [HZ_W-1:0]     r_rem;
    logic [HZ_W-1:0]     r_div;
    logic [DIV_BITS-1:0] r_quo;

    logic [HZ_W:0]       n_trial;
    logic [HZ_W-1:0]     n_rem;
    logic                n_qbit;

    // one restoring step
    always_comb begin
        n_trial = {r_rem, NS_PER_SEC[r_bit]};
        if (n_trial >= {1'b0, r_div}) begin
            n_rem  = HZ_W'(n_trial - {1'b0, r_div});
            n_qbit = 1'b1;
        end else begin
            n_rem  = HZ_W'(n_trial);
            n_qbit = 1'b0;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // remainder, quotient and bit index
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bit <= BIT_W'(DIV_BITS - 1);
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_BITS-2:0], n_qbit};
            if (r_bit != '0) begin
                r_bit <= r_bit - 1'b1;
            end
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: hw/rtl/pts_datapath.sv
// Datapath: beep queue memory, countdown, tone state, divider, result register.
// Depends on pts_pkg, pts_div and the assertion macro header.
`include "pwm_tone_sequencer_unit_defines.svh"

module pts_datapath
    import pts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_ctrl_cmd           i_cmd,
    output t_dp_status          o_status,
    input  logic [1:0]          i_command,
    input  logic [HZ_W-1:0]     i_tone_hz,
    input  logic [MS_W-1:0]     i_duration_ms,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    output logic                o_pwm_on,
    output logic [PERIOD_W-1:0] o_period_ns,
    output logic [HIGH_W-1:0]   o_high_ns,
    output logic                o_pwm_polarity,
    output logic [HZ_W-1:0]     o_current_hz,
    output logic [QCNT_W-1:0]   o_queued_count,
    output logic                o_push_dropped
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = HZ_W + MS_W;

    // queue memory and registered head entry
    logic [ENT_W-1:0] r_mem [QUEUE_DEPTH];
    logic [ENT_W-1:0] r_head;

    // sequencer state
    logic [PTR_W-1:0] r_rd_ptr,  n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr,  n_wr_ptr;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [MS_W-1:0]  r_remain,  n_remain;
    logic             r_active,  n_active;
    logic [HZ_W-1:0]  r_playing, n_playing;
    logic             r_dropped, n_dropped;
    logic             r_polarity;
    logic             wr_en;

    // result register
    logic                r_pwm_on;
    logic [PERIOD_W-1:0] r_period;
    logic [HIGH_W-1:0]   r_high;
    logic                r_pol_out;
    logic [HZ_W-1:0]     r_cur_hz;
    logic [QCNT_W-1:0]   r_qcnt;
    logic                r_drop_out;

    logic [DIV_BITS-1:0] quotient;
    logic [PERIOD_W-1:0] period_val;
    logic                div_done;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // command execution
    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_remain  = r_remain;
        n_active  = r_active;
        n_playing = r_playing;
        n_dropped = 1'b0;
        wr_en     = 1'b0;
        case (t_command'(i_command))
            CMD_TICK: begin
                if (r_active) begin
                    if (r_remain <= MS_W'(1)) begin
                        // countdown expired: pop next beep or fall silent
                        if (r_count == '0) begin
                            n_playing = '0;
                            n_active  = 1'b0;
                            n_remain  = '0;
                        end else begin
                            n_rd_ptr  = next_ptr(r_rd_ptr);
                            n_count   = r_count - 1'b1;
                            n_playing = r_head[ENT_W-1:MS_W];
                            n_remain  = r_head[MS_W-1:0];
                            n_active  = 1'b1;
                        end
                    end else begin
                        n_remain = r_remain - 1'b1;
                    end
                end
            end
            CMD_BEEP: begin
                if ((i_tone_hz == '0) && (i_duration_ms == '0)) begin
                    // stop: flush queue and silence
                    n_active  = 1'b0;
                    n_remain  = '0;
                    n_count   = '0;
                    n_rd_ptr  = '0;
                    n_wr_ptr  = '0;
                    n_playing = '0;
                end else if (r_count >= CNT_W'(QUEUE_DEPTH)) begin
                    n_dropped = 1'b1;
                end else begin
                    wr_en    = 1'b1;
                    n_wr_ptr = next_ptr(r_wr_ptr);
                    n_count  = r_count + 1'b1;
                    if (r_count == '0) begin
                        n_remain = MS_W'(1);
                        n_active = 1'b1;
                    end
                end
            end
            CMD_SET: begin
                n_playing = i_tone_hz;
            end
            default: begin
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr   <= '0;
            r_wr_ptr   <= '0;
            r_count    <= '0;
            r_remain   <= '0;
            r_active   <= 1'b0;
            r_playing  <= '0;
            r_dropped  <= 1'b0;
            r_polarity <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_rd_ptr  <= n_rd_ptr;
                r_wr_ptr  <= n_wr_ptr;
                r_count   <= n_count;
                r_remain  <= n_remain;
                r_active  <= n_active;
                r_playing <= n_playing;
                r_dropped <= n_dropped;
            end
            if (i_cfg_we) begin
                r_polarity <= i_cfg_wdata;
            end
        end
    end

    // queue memory: one write port, registered read at the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[r_wr_ptr] <= {i_tone_hz, i_duration_ms};
        end
        r_head <= r_mem[r_rd_ptr];
    end

    // period divider
    pts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_divisor  (r_playing),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    assign o_status.div_done = div_done;
    assign period_val = (r_playing != '0) ? PERIOD_W'(quotient) : '0;

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_pwm_on   <= (r_playing != '0);
            r_period   <= period_val;
            r_high     <= period_val[PERIOD_W-1:1];
            r_pol_out  <= r_polarity;
            r_cur_hz   <= r_playing;
            r_qcnt     <= QCNT_W'(r_count);
            r_drop_out <= r_dropped;
        end
    end

    assign o_pwm_on       = r_pwm_on;
    assign o_period_ns    = r_period;
    assign o_high_ns      = r_high;
    assign o_pwm_polarity = r_pol_out;
    assign o_current_hz   = r_cur_hz;
    assign o_queued_count = r_qcnt;
    assign o_push_dropped = r_drop_out;

    // checks
    `PTS_ASSERT_NEVER(a_count_bounded, i_clk, i_rst_n, r_count > CNT_W'(QUEUE_DEPTH))
    `PTS_ASSERT_IMPL(a_stopped_zero_remain, i_clk, i_rst_n, !r_active, r_remain == '0)
    `PTS_ASSERT_IMPL(a_queued_implies_active, i_clk, i_rst_n, r_count != '0, r_active)

endmodule

// File: hw/rtl/pwm_tone_sequencer_unit.sv
// Top level of the PWM tone sequencer: controller plus datapath.
// Depends on pts_pkg, pts_ctrl and pts_datapath.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------------
//  input    | i_in_valid / o_in_ready   | i_command, i_tone_hz, i_duration_ms
//  result   | o_out_valid / i_out_ready | o_pwm_on ... o_push_dropped
//  config   | i_cfg_we (no wait)        | i_cfg_wdata (output polarity)
//
// From acceptance to a valid result, each item passes through the 30-step
// restoring divider that forms the PWM period.
// A new item is taken while an earlier result still waits at the output.
// Synchronous active-low reset; the queue memory needs no clearing pass.
// A stalled result holds the finished next one in the divider until taken.
module pwm_tone_sequencer_unit
    import pts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_command,
    input  logic [HZ_W-1:0]     i_tone_hz,
    input  logic [MS_W-1:0]     i_duration_ms,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_pwm_on,
    output logic [PERIOD_W-1:0] o_period_ns,
    output logic [HIGH_W-1:0]   o_high_ns,
    output logic                o_pwm_polarity,
    output logic [HZ_W-1:0]     o_current_hz,
    output logic [QCNT_W-1:0]   o_queued_count,
    output logic                o_push_dropped,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // controller
    pts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // datapath
    pts_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_command      (i_command),
        .i_tone_hz      (i_tone_hz),
        .i_duration_ms  (i_duration_ms),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_pwm_on       (o_pwm_on),
        .o_period_ns    (o_period_ns),
        .o_high_ns      (o_high_ns),
        .o_pwm_polarity (o_pwm_polarity),
        .o_current_hz   (o_current_hz),
        .o_queued_count (o_queued_count),
        .o_push_dropped (o_push_dropped)
    );

endmodule

// File: test/pts_tone_checker.sv
// Checker for the PWM tone sequencer: watches both channels and the polarity
// write, keeps its own copy of the beep queue and compares every result.
// Depends on pts_pkg for widths, command codes and the period dividend.
module pts_tone_checker
    import pts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [1:0]          i_command,
    input  logic [HZ_W-1:0]     i_tone_hz,
    input  logic [MS_W-1:0]     i_duration_ms,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_pwm_on,
    input  logic [PERIOD_W-1:0] i_period_ns,
    input  logic [HIGH_W-1:0]   i_high_ns,
    input  logic                i_pwm_polarity,
    input  logic [HZ_W-1:0]     i_current_hz,
    input  logic [QCNT_W-1:0]   i_queued_count,
    input  logic                i_push_dropped,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    output int                  o_fail_count,
    output int                  o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic                pwm_on;
        logic [PERIOD_W-1:0] period_ns;
        logic [HIGH_W-1:0]   high_ns;
        logic                pwm_polarity;
        logic [HZ_W-1:0]     current_hz;
        logic [QCNT_W-1:0]   queued_count;
        logic                push_dropped;
    } t_tone_status;

    // sequencer state as the block should hold it
    logic [HZ_W+MS_W-1:0] beep_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]     rd_ptr;
    logic [PTR_W-1:0]     wr_ptr;
    logic [CNT_W-1:0]     beep_count;
    logic [MS_W-1:0]      ms_left;
    logic                 countdown_on;
    logic [HZ_W-1:0]      tone_hz;
    logic                 polarity;

    t_tone_status status_q[$];
    int           fail_count = 0;
    int           pending_count = 0;

    assign o_fail_count    = fail_count;
    assign o_pending_count = pending_count;

    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] ptr);
        return (int'(ptr) + 1 >= QUEUE_DEPTH) ? '0 : ptr + 1'b1;
    endfunction

    // advance the sequencer by one item and return the status it reports
    function automatic t_tone_status apply_item(logic [1:0] cmd, logic [HZ_W-1:0] hz,
                                                logic [MS_W-1:0] ms);
        t_tone_status        s;
        logic [HZ_W+MS_W-1:0] entry;
        logic [PERIOD_W-1:0] period;
        s.push_dropped = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (countdown_on) begin
                    if (ms_left <= 1) begin
                        // countdown expired: pop the next beep or fall silent
                        if (beep_count == 0) begin
                            tone_hz      = '0;
                            countdown_on = 1'b0;
                            ms_left      = '0;
                        end else begin
                            entry        = beep_mem[rd_ptr];
                            rd_ptr       = next_ptr(rd_ptr);
                            beep_count   = beep_count - 1'b1;
                            tone_hz      = entry[HZ_W+MS_W-1:MS_W];
                            ms_left      = entry[MS_W-1:0];
                            countdown_on = 1'b1;
                        end
                    end else begin
                        ms_left = ms_left - 1'b1;
                    end
                end
            end
            CMD_BEEP: begin
                if (hz == 0 && ms == 0) begin
                    // stop: flush the queue and go quiet
                    countdown_on = 1'b0;
                    ms_left      = '0;
                    beep_count   = '0;
                    rd_ptr       = '0;
                    wr_ptr       = '0;
                    tone_hz      = '0;
                end else if (int'(beep_count) >= QUEUE_DEPTH) begin
                    s.push_dropped = 1'b1;
                end else begin
                    beep_mem[wr_ptr] = {hz, ms};
                    wr_ptr           = next_ptr(wr_ptr);
                    beep_count       = beep_count + 1'b1;
                    // first beep into an empty queue re-arms at 1 ms
                    if (beep_count == 1) begin
                        ms_left      = 1;
                        countdown_on = 1'b1;
                    end
                end
            end
            CMD_SET: tone_hz = hz;
            default: ;
        endcase
        period = (tone_hz != 0) ? NS_PER_SEC / PERIOD_W'(tone_hz) : '0;
        s.pwm_on       = (tone_hz != 0);
        s.period_ns    = period;
        s.high_ns      = HIGH_W'(period >> 1);
        s.pwm_polarity = polarity;
        s.current_hz   = tone_hz;
        s.queued_count = QCNT_W'(beep_count);
        return s;
    endfunction

    task automatic check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge i_clk) begin : monitor
        t_tone_status want;
        if (!i_rst_n) begin
            rd_ptr       = '0;
            wr_ptr       = '0;
            beep_count   = '0;
            ms_left      = '0;
            countdown_on = 1'b0;
            tone_hz      = '0;
            polarity     = 1'b0;
            status_q.delete();
        end else begin
            if (i_cfg_we)
                polarity = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: extra result, expected none, got hz %0d period %0d",
                             $time, i_current_hz, i_period_ns);
                end else begin
                    want = status_q.pop_front();
                    check_field("pwm_on", want.pwm_on, i_pwm_on);
                    check_field("period_ns", want.period_ns, i_period_ns);
                    check_field("high_ns", want.high_ns, i_high_ns);
                    check_field("pwm_polarity", want.pwm_polarity, i_pwm_polarity);
                    check_field("current_hz", want.current_hz, i_current_hz);
                    check_field("queued_count", want.queued_count, i_queued_count);
                    check_field("push_dropped", want.push_dropped, i_push_dropped);
                end
            end
            if (i_in_valid && i_in_ready)
                status_q.push_back(apply_item(i_command, i_tone_hz, i_duration_ms));
        end
        pending_count <= status_q.size();
    end

endmodule

// File: test/pwm_tone_sequencer_unit_tb.sv
// Testbench top for the PWM tone sequencer: clock, reset, bursty beep and
// tick stimulus, a stalling result sink and the final verdict.
// Depends on pts_pkg, pwm_tone_sequencer_unit and pts_tone_checker.
module pwm_tone_sequencer_unit_tb;
    import pts_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH  = 16;
    localparam int PHASE_ITEMS  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 600000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [1:0]          command = CMD_TICK;
    logic [HZ_W-1:0]     tone_hz = '0;
    logic [MS_W-1:0]     duration_ms = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                pwm_on;
    logic [PERIOD_W-1:0] period_ns;
    logic [HIGH_W-1:0]   high_ns;
    logic                pwm_polarity;
    logic [HZ_W-1:0]     current_hz;
    logic [QCNT_W-1:0]   queued_count;
    logic                push_dropped;
    logic                cfg_we = 1'b0;
    logic                cfg_wdata = 1'b0;

    int fail_count;
    int pending_count;
    int cycle_count = 0;
    int items_sent = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;

    always #1 clk = ~clk;

    pwm_tone_sequencer_unit #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_command      (command),
        .i_tone_hz      (tone_hz),
        .i_duration_ms  (duration_ms),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pwm_on       (pwm_on),
        .o_period_ns    (period_ns),
        .o_high_ns      (high_ns),
        .o_pwm_polarity (pwm_polarity),
        .o_current_hz   (current_hz),
        .o_queued_count (queued_count),
        .o_push_dropped (push_dropped),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata)
    );

    pts_tone_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_command       (command),
        .i_tone_hz       (tone_hz),
        .i_duration_ms   (duration_ms),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_pwm_on        (pwm_on),
        .i_period_ns     (period_ns),
        .i_high_ns       (high_ns),
        .i_pwm_polarity  (pwm_polarity),
        .i_current_hz    (current_hz),
        .i_queued_count  (queued_count),
        .i_push_dropped  (push_dropped),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    // watchdog
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[pwm_tone_sequencer_unit] ERROR");
        $finish;
    end

    // result sink: ready pattern switches between free flow, coin flips
    // and long stalls
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // present one item and hold it until accepted; valid stays high on return
    task automatic send_item(logic [1:0] cmd, logic [HZ_W-1:0] hz, logic [MS_W-1:0] ms);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid    <= 1'b1;
        command     <= cmd;
        tone_hz     <= hz;
        duration_ms <= ms;
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
    endtask

    task automatic write_polarity(logic value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [HZ_W-1:0] pick_tone_hz();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return ($urandom_range(0, 1) != 0) ? HZ_W'(1) : '1;
            2:       return HZ_W'($urandom_range(1, 1000));
            default: return HZ_W'($urandom_range(1, 65535));
        endcase
    endfunction

    // mostly short beeps so the queue actually plays out
    function automatic logic [MS_W-1:0] pick_length_ms();
        case ($urandom_range(0, 9))
            7, 8:    return MS_W'($urandom_range(5, 40));
            9:       return MS_W'($urandom);
            default: return MS_W'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic play_random_beeps(int count);
        int stop_at;
        int kind;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            kind = $urandom_range(0, 19);
            if (kind < 12) begin
                // queue a few beeps, then tick them out
                repeat ($urandom_range(1, 6))
                    send_item(CMD_BEEP, pick_tone_hz(), pick_length_ms());
                if ($urandom_range(0, 5) == 0)
                    send_item(CMD_SET, pick_tone_hz(), MS_W'($urandom));
                repeat ($urandom_range(2, 30))
                    send_item(CMD_TICK, HZ_W'($urandom), MS_W'($urandom));
            end else if (kind < 15) begin
                // push toward or past the queue depth
                repeat ($urandom_range(14, 20))
                    send_item(CMD_BEEP, pick_tone_hz(), pick_length_ms());
            end else if (kind < 19) begin
                // noise: any command with any fields, plus the odd stop
                repeat ($urandom_range(1, 8))
                    send_item(2'($urandom_range(0, 3)), HZ_W'($urandom), MS_W'($urandom));
                if ($urandom_range(0, 2) == 0)
                    send_item(CMD_BEEP, '0, '0);
            end else begin
                drain_results();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_polarity(1'b0);

        // directed: idle tick, period extremes, unused code, queue play-out
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_SET, HZ_W'(1), '0);
        send_item(CMD_SET, '1, '0);
        send_item(CMD_SET, '0, '1);
        send_item(CMD_UNUSED, '1, '1);
        send_item(CMD_BEEP, HZ_W'(440), MS_W'(3));
        send_item(CMD_BEEP, '0, MS_W'(2));
        send_item(CMD_BEEP, '1, '0);
        repeat (5) send_item(CMD_TICK, '0, '0);
        send_item(CMD_SET, HZ_W'(1000), '0);
        repeat (3) send_item(CMD_TICK, '1, '1);
        send_item(CMD_BEEP, HZ_W'(1), '1);
        send_item(CMD_BEEP, '0, '0);
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_BEEP, HZ_W'(12345), MS_W'(1));
        send_item(CMD_TICK, '0, '0);
        send_item(CMD_TICK, '0, '0);

        write_polarity(1'b1);
        play_random_beeps(PHASE_ITEMS);
        write_polarity(1'b0);
        play_random_beeps(PHASE_ITEMS);
        write_polarity(1'b1);
        play_random_beeps(PHASE_ITEMS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("[pwm_tone_sequencer_unit] OK");
        else
            $display("[pwm_tone_sequencer_unit] ERROR");
        $finish;
    end

endmodule
